// ===== rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg : shared constants for the box-filter thumbnail downscaler
// Field widths, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfd_pkg;

   localparam int DEF_MAX_SRC_SIZE  = 4096;
   localparam int DEF_MAX_DST_SIZE  = 256;
   localparam int DEF_FRACTION_BITS = 12;

   localparam int CH_W      = 8;   // one colour channel
   localparam int NUM_CH    = 3;
   localparam int SRC_CFG_W = 13;
   localparam int DST_CFG_W = 9;
   localparam int STEP_W    = 25;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 25;
   localparam int COORD_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_STEP  = 3'd5;

endpackage

// ===== rtl/bfd_span_bounds.sv =====
// ----------------------------------------------------------------------------
// bfd_span_bounds : span start and end from a Q position
// End is rounded, clamped to the limit and kept past the start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfd_span_bounds #(
   parameter int POS_W         = 35,
   parameter int CNT_W         = 13,
   parameter int FRACTION_BITS = bfd_pkg::DEF_FRACTION_BITS
) (
   input  logic [POS_W-1:0]                 pos,
   input  logic [bfd_pkg::STEP_W-1:0]       step,
   input  logic [CNT_W-1:0]                 limit,
   output logic [POS_W-FRACTION_BITS-1:0]   lo,
   output logic [POS_W-FRACTION_BITS:0]     hi
);

   localparam int LO_W = POS_W - FRACTION_BITS;
   localparam int HI_W = LO_W + 1;

   logic [POS_W:0] end_q;
   logic [HI_W-1:0] b;

   always_comb begin
      end_q = {1'b0, pos} + (POS_W+1)'(step) + (POS_W+1)'(1 << (FRACTION_BITS - 1));
      lo    = pos[POS_W-1:FRACTION_BITS];
      b     = end_q[POS_W:FRACTION_BITS];
      if (b > HI_W'(limit)) begin
         b = HI_W'(limit);
      end
      if (b <= {1'b0, lo}) begin
         b = {1'b0, lo} + HI_W'(1);
      end
      hi = b;
   end

endmodule

// ===== rtl/bfd_divider.sv =====
// ----------------------------------------------------------------------------
// bfd_divider : three-lane restoring divider, one quotient bit a cycle
// Lanes share the divisor; the dividend shift register fills with quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfd_divider #(
   parameter int SUM_W = 20,
   parameter int DIV_W = 13
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [DIV_W-1:0]                        divisor,
   input  logic [bfd_pkg::NUM_CH-1:0][SUM_W-1:0]   dividend,
   output logic [bfd_pkg::NUM_CH-1:0][SUM_W-1:0]   quotient,
   output logic                                    busy,
   output logic                                    done
);

   localparam int CW = $clog2(SUM_W + 1);

   logic                                  busy_ff;
   logic                                  done_ff;
   logic [CW-1:0]                         cnt_ff;
   logic [DIV_W-1:0]                      div_ff;
   logic [bfd_pkg::NUM_CH-1:0][SUM_W-1:0] dvd_ff;
   logic [bfd_pkg::NUM_CH-1:0][DIV_W-1:0] rem_ff;
   logic [bfd_pkg::NUM_CH-1:0][DIV_W-1:0] rem_in;
   logic [bfd_pkg::NUM_CH-1:0]            qbit;

   always_comb begin
      for (int l = 0; l < bfd_pkg::NUM_CH; l++) begin
         logic [DIV_W:0] trial;
         trial = {rem_ff[l], dvd_ff[l][SUM_W-1]};
         if (trial >= {1'b0, div_ff}) begin
            trial   = trial - {1'b0, div_ff};
            qbit[l] = 1'b1;
         end else begin
            qbit[l] = 1'b0;
         end
         rem_in[l] = trial[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            div_ff  <= divisor;
            dvd_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            for (int l = 0; l < bfd_pkg::NUM_CH; l++) begin
               dvd_ff[l] <= {dvd_ff[l][SUM_W-2:0], qbit[l]};
               rem_ff[l] <= rem_in[l];
            end
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = dvd_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/box_filter_thumbnail_downscaler.sv =====
// ----------------------------------------------------------------------------
// box_filter_thumbnail_downscaler : area-average RGB thumbnail downscaler
// Source pixels are taken one at a time; a pixel that ends a row span waits
//   on the bit-serial divider, and one that completes a thumbnail pixel waits
//   on it twice, once per span pass (SUM_W = 20 quotient bits by default).
// A thumbnail beat waits in the output register until it can leave; only the
//   next emit step is held for it, and the sequencer goes on meanwhile.
// Reset (synchronous) and every frame end start a clearing pass over all
//   2*MAX_DST_SIZE entries of the column-sum memory; no pixel is taken then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_thumbnail_downscaler #(
   parameter int MAX_SRC_SIZE  = bfd_pkg::DEF_MAX_SRC_SIZE,
   parameter int MAX_DST_SIZE  = bfd_pkg::DEF_MAX_DST_SIZE,
   parameter int FRACTION_BITS = bfd_pkg::DEF_FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // source pixel beats
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,   // red, green, blue
   // thumbnail pixel beats
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,   // out_x, out_y, red, green, blue
   output logic                            rsp_tlast,   // run_last
   output logic                            rsp_tuser,   // frame_done
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfd_pkg::CSR_DAT_W-1:0]   csr_data
);

   localparam int CNT_W = $clog2(MAX_SRC_SIZE + 1);
   localparam int IDX_W = $clog2(MAX_DST_SIZE + 1);
   localparam int SUM_W = bfd_pkg::CH_W + $clog2(MAX_SRC_SIZE);
   localparam int POS_W = IDX_W + bfd_pkg::STEP_W + 1;
   localparam int LO_W  = POS_W - FRACTION_BITS;
   localparam int HI_W  = LO_W + 1;
   localparam int DEPTH = 2 * MAX_DST_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int MEM_W = IDX_W + bfd_pkg::NUM_CH * SUM_W;
   localparam int NC    = bfd_pkg::NUM_CH;
   localparam int CH_W  = bfd_pkg::CH_W;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_H1, S_H2, S_V1, S_V2, S_HUPD, S_HDIV,
      S_RDC, S_RDN, S_WRN, S_VDIV, S_EMIT, S_HFIN, S_END
   } state_type;

   state_type state_ff;

   // configuration
   logic [bfd_pkg::SRC_CFG_W-1:0] src_width_ff, src_height_ff;
   logic [bfd_pkg::DST_CFG_W-1:0] dst_width_ff, dst_height_ff;
   logic [bfd_pkg::STEP_W-1:0]    horiz_step_ff, vert_step_ff;

   // frame walk
   logic [CNT_W-1:0] col_ff, row_ff;
   logic [POS_W-1:0] hpos_ff, hnext_ff, vpos_ff, vnext_ff;
   logic [IDX_W-1:0] hk_ff, vk_ff;
   logic [AW-1:0]    clr_ff;

   // per-pixel flags from the span tests
   logic             hin_cur_ff, hin_nxt_ff, hend_ff;
   logic             vin_cur_ff, vin_nxt_ff, vend_ff;
   logic [CNT_W-1:0] hlen_ff, vlen_ff;

   logic [NC-1:0][CH_W-1:0]  pix_ff;
   logic [NC-1:0][SUM_W-1:0] rs0_ff, rs1_ff;
   logic [NC-1:0][CH_W-1:0]  avg_ff;
   logic [NC-1:0][SUM_W-1:0] csum_ff;

   // output register
   logic                    rsp_valid_ff;
   logic [39:0]             rsp_data_ff;
   logic                    rsp_user_ff;

   // clamped sizes and steps
   logic [CNT_W-1:0]           w, h;
   logic [IDX_W-1:0]           dw, dh;
   logic [bfd_pkg::STEP_W-1:0] hs, vs;

   always_comb begin
      if (32'(src_width_ff) > MAX_SRC_SIZE)       w = CNT_W'(MAX_SRC_SIZE);
      else if (src_width_ff == '0)               w = CNT_W'(1);
      else                                       w = CNT_W'(src_width_ff);
      if (32'(src_height_ff) > MAX_SRC_SIZE)      h = CNT_W'(MAX_SRC_SIZE);
      else if (src_height_ff == '0)              h = CNT_W'(1);
      else                                       h = CNT_W'(src_height_ff);
      if (32'(dst_width_ff) > MAX_DST_SIZE)       dw = IDX_W'(MAX_DST_SIZE);
      else if (dst_width_ff == '0)               dw = IDX_W'(1);
      else                                       dw = IDX_W'(dst_width_ff);
      if (32'(dst_height_ff) > MAX_DST_SIZE)      dh = IDX_W'(MAX_DST_SIZE);
      else if (dst_height_ff == '0)              dh = IDX_W'(1);
      else                                       dh = IDX_W'(dst_height_ff);
      if (32'(horiz_step_ff) < (1 << FRACTION_BITS))
         hs = bfd_pkg::STEP_W'(1 << FRACTION_BITS);
      else
         hs = horiz_step_ff;
      if (32'(vert_step_ff) < (1 << FRACTION_BITS))
         vs = bfd_pkg::STEP_W'(1 << FRACTION_BITS);
      else
         vs = vert_step_ff;
   end

   // one shared bounds unit, fed per state
   logic [POS_W-1:0]           bpos;
   logic [bfd_pkg::STEP_W-1:0] bstep;
   logic [CNT_W-1:0]           blim;
   logic [LO_W-1:0]            blo;
   logic [HI_W-1:0]            bhi;
   logic [HI_W-1:0]            here, here1;

   always_comb begin
      case (state_ff)
         S_H1:    bpos = hpos_ff;
         S_H2:    bpos = hnext_ff;
         S_V1:    bpos = vpos_ff;
         default: bpos = vnext_ff;
      endcase
      bstep = (state_ff == S_H1 || state_ff == S_H2) ? hs : vs;
      blim  = (state_ff == S_H1 || state_ff == S_H2) ? w : h;
      here  = (state_ff == S_H1 || state_ff == S_H2) ? HI_W'(col_ff) : HI_W'(row_ff);
      here1 = here + HI_W'(1);
   end

   bfd_span_bounds #(
      .POS_W(POS_W), .CNT_W(CNT_W), .FRACTION_BITS(FRACTION_BITS)
   ) u_bounds (
      .pos(bpos), .step(bstep), .limit(blim), .lo(blo), .hi(bhi)
   );

   logic in_span;
   assign in_span = ({1'b0, blo} <= here) && (here < bhi);

   // shared divider
   logic                     div_start;
   logic [CNT_W-1:0]         div_divisor;
   logic [NC-1:0][SUM_W-1:0] div_dividend;
   logic [NC-1:0][SUM_W-1:0] div_quot;
   logic                     div_busy, div_done;

   // row sums after this pixel
   logic [NC-1:0][SUM_W-1:0] rs0_add, rs1_add;
   logic                     hact, hnext_ok, hcomplete;

   always_comb begin
      hact      = hk_ff < dw;
      hnext_ok  = (hk_ff + IDX_W'(1)) < dw;
      hcomplete = hact && hend_ff;
      for (int c = 0; c < NC; c++) begin
         rs0_add[c] = rs0_ff[c] + ((hact && hin_cur_ff) ? SUM_W'(pix_ff[c]) : '0);
         rs1_add[c] = rs1_ff[c] +
                      ((hact && hnext_ok && hin_nxt_ff) ? SUM_W'(pix_ff[c]) : '0);
      end
      div_start    = 1'b0;
      div_divisor  = hlen_ff;
      div_dividend = rs0_add;
      if (state_ff == S_HUPD) begin
         div_start = hcomplete;
      end else if (state_ff == S_WRN) begin
         div_start    = vend_ff;
         div_divisor  = vlen_ff;
         div_dividend = csum_ff;
      end
   end

   bfd_divider #(.SUM_W(SUM_W), .DIV_W(CNT_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .divisor(div_divisor),
      .dividend(div_dividend), .quotient(div_quot), .busy(div_busy), .done(div_done)
   );

   // column sums: entry {k, span parity} holds {tag = vertical span, sums}.
   // A tag that is not the span asked for reads as zero, which stands in for
   // moving the next-span sums down at each vertical span end.
   logic [MEM_W-1:0] mem [DEPTH];
   logic [MEM_W-1:0] mem_q;
   logic [AW-1:0]    raddr, waddr;
   logic             wen;
   logic [MEM_W-1:0] wdata;
   logic [AW-1:0]    addr_cur, addr_nxt;
   logic [IDX_W-1:0] vk1;
   logic [NC-1:0][SUM_W-1:0] q_sums, upd_sums;
   logic [IDX_W-1:0] q_tag;
   logic             vnext_ok;

   always_comb begin
      addr_cur = {hk_ff[AW-2:0], vk_ff[0]};
      addr_nxt = {hk_ff[AW-2:0], ~vk_ff[0]};
      vk1      = vk_ff + IDX_W'(1);
      vnext_ok = vk1 < dh;
      q_tag    = mem_q[MEM_W-1 -: IDX_W];
      for (int c = 0; c < NC; c++) begin
         q_sums[c] = mem_q[c*SUM_W +: SUM_W];
      end
      raddr = (state_ff == S_RDN) ? addr_nxt : addr_cur;
      wen   = 1'b0;
      waddr = addr_cur;
      wdata = '0;
      for (int c = 0; c < NC; c++) begin
         upd_sums[c] = '0;
      end
      case (state_ff)
         S_CLR: begin
            wen   = 1'b1;
            waddr = clr_ff;
         end
         S_RDN: begin
            for (int c = 0; c < NC; c++) begin
               upd_sums[c] = ((q_tag == vk_ff) ? q_sums[c] : '0) +
                             (vin_cur_ff ? SUM_W'(avg_ff[c]) : '0);
            end
            wen   = 1'b1;
            wdata = {vk_ff, upd_sums};
         end
         S_WRN: begin
            for (int c = 0; c < NC; c++) begin
               upd_sums[c] = ((q_tag == vk1) ? q_sums[c] : '0) +
                             ((vnext_ok && vin_nxt_ff) ? SUM_W'(avg_ff[c]) : '0);
            end
            wen   = 1'b1;
            waddr = addr_nxt;
            wdata = {vk1, upd_sums};
         end
         default: begin
            wen = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      mem_q <= mem[raddr];
   end

   logic in_fire, out_free;
   assign req_tready = (state_ff == S_IDLE);
   assign in_fire    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // main sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_ff        <= '0;
         src_width_ff  <= bfd_pkg::SRC_CFG_W'(1);
         src_height_ff <= bfd_pkg::SRC_CFG_W'(1);
         dst_width_ff  <= bfd_pkg::DST_CFG_W'(1);
         dst_height_ff <= bfd_pkg::DST_CFG_W'(1);
         horiz_step_ff <= bfd_pkg::STEP_W'(1 << FRACTION_BITS);
         vert_step_ff  <= bfd_pkg::STEP_W'(1 << FRACTION_BITS);
         col_ff        <= '0;
         row_ff        <= '0;
         hpos_ff       <= '0;
         vpos_ff       <= '0;
         hk_ff         <= '0;
         vk_ff         <= '0;
         rs0_ff        <= '0;
         rs1_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               bfd_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data[bfd_pkg::SRC_CFG_W-1:0];
               bfd_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data[bfd_pkg::SRC_CFG_W-1:0];
               bfd_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_data[bfd_pkg::DST_CFG_W-1:0];
               bfd_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_data[bfd_pkg::DST_CFG_W-1:0];
               bfd_pkg::CSR_HORIZ_STEP: horiz_step_ff <= csr_data;
               bfd_pkg::CSR_VERT_STEP:  vert_step_ff  <= csr_data;
               default: ;
            endcase
         end

         // the emit step loads the next beat itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (in_fire) begin
                  for (int c = 0; c < NC; c++) begin
                     pix_ff[c] <= req_tdata[c*CH_W +: CH_W];
                  end
                  state_ff <= S_H1;
               end
            end
            S_H1: begin
               hin_cur_ff <= in_span;
               hend_ff    <= (here1 == bhi);
               hlen_ff    <= CNT_W'(bhi - {1'b0, blo});
               hnext_ff   <= hpos_ff + POS_W'(hs);
               state_ff   <= S_H2;
            end
            S_H2: begin
               hin_nxt_ff <= in_span;
               state_ff   <= S_V1;
            end
            S_V1: begin
               vin_cur_ff <= in_span;
               vend_ff    <= (here1 == bhi);
               vlen_ff    <= CNT_W'(bhi - {1'b0, blo});
               vnext_ff   <= vpos_ff + POS_W'(vs);
               state_ff   <= S_V2;
            end
            S_V2: begin
               vin_nxt_ff <= in_span;
               state_ff   <= S_HUPD;
            end
            S_HUPD: begin
               if (hcomplete) begin
                  // completed span leaves; next span's sums move down
                  rs0_ff   <= rs1_add;
                  rs1_ff   <= '0;
                  state_ff <= S_HDIV;
               end else begin
                  rs0_ff   <= rs0_add;
                  rs1_ff   <= rs1_add;
                  state_ff <= S_END;
               end
            end
            S_HDIV: begin
               if (div_done) begin
                  for (int c = 0; c < NC; c++) begin
                     avg_ff[c] <= div_quot[c][CH_W-1:0];
                  end
                  state_ff <= (vk_ff < dh) ? S_RDC : S_HFIN;
               end
            end
            S_RDC: begin
               state_ff <= S_RDN;
            end
            S_RDN: begin
               csum_ff  <= upd_sums;
               state_ff <= S_WRN;
            end
            S_WRN: begin
               state_ff <= vend_ff ? S_VDIV : S_HFIN;
            end
            S_VDIV: begin
               if (div_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {div_quot[2][CH_W-1:0], div_quot[1][CH_W-1:0],
                                   div_quot[0][CH_W-1:0],
                                   vk_ff[bfd_pkg::COORD_W-1:0],
                                   hk_ff[bfd_pkg::COORD_W-1:0]};
                  rsp_user_ff  <= ((hk_ff + IDX_W'(1)) == dw) && (vk1 == dh);
                  state_ff     <= S_HFIN;
               end
            end
            S_HFIN: begin
               hk_ff    <= hk_ff + IDX_W'(1);
               hpos_ff  <= hnext_ff;
               state_ff <= S_END;
            end
            S_END: begin
               if (({1'b0, col_ff} + (CNT_W+1)'(1)) >= {1'b0, w}) begin
                  col_ff  <= '0;
                  hk_ff   <= '0;
                  hpos_ff <= '0;
                  rs0_ff  <= '0;
                  rs1_ff  <= '0;
                  if (({1'b0, row_ff} + (CNT_W+1)'(1)) >= {1'b0, h}) begin
                     // frame end: back to reset state, sweep the column sums
                     row_ff   <= '0;
                     vk_ff    <= '0;
                     vpos_ff  <= '0;
                     clr_ff   <= '0;
                     state_ff <= S_CLR;
                  end else begin
                     row_ff <= row_ff + CNT_W'(1);
                     if (vk_ff < dh && vend_ff) begin
                        vk_ff   <= vk1;
                        vpos_ff <= vnext_ff;
                     end
                     state_ff <= S_IDLE;
                  end
               end else begin
                  col_ff   <= col_ff + CNT_W'(1);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = 1'b1;
   assign rsp_tuser  = rsp_user_ff;

   // a new pixel is only taken with the divider at rest
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_busy)
      else $error("pixel taken while divider busy");

   // a result appears only from the emit step
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside emit");

   // divider results are only awaited after a start
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HDIV || state_ff == S_VDIV) |-> (div_busy || div_done))
      else $error("waiting on idle divider");

   // no pending beat is overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("output beat overwritten");

endmodule

// ===== sim/bfd_checker.sv =====
// ----------------------------------------------------------------------------
// bfd_checker : thumbnail pixel predictor and scoreboard
// Watches the register, source and thumbnail channels, works out the expected
// thumbnail pixels for every accepted source beat and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfd_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // red, green, blue
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [39:0]                   rsp_tdata,   // out_x, out_y, red, green, blue
   input  logic                          rsp_tlast,   // run_last
   input  logic                          rsp_tuser,   // frame_done
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfd_pkg::CSR_DAT_W-1:0] csr_data,
   output int                            errors,
   output int                            pending
);

   localparam int FRAC = bfd_pkg::DEF_FRACTION_BITS;
   localparam int MAXS = bfd_pkg::DEF_MAX_SRC_SIZE;
   localparam int MAXD = bfd_pkg::DEF_MAX_DST_SIZE;

   typedef struct packed {
      logic [7:0] x, y, red, green, blue;
      logic       last, done;
   } thumb_px_type;

   thumb_px_type thumb_q[$];

   int unsigned reg_sw, reg_sh, reg_dw, reg_dh, reg_hs, reg_vs;
   int unsigned col_cnt, row_cnt, hspan, vspan;
   longint unsigned hpos, vpos;
   int unsigned row_acc[2][3];
   int unsigned col_acc[2*MAXD][3];

   function automatic longint unsigned clampv(longint unsigned v, lo, hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void span_of(input longint unsigned pos, stp, lim,
                                   output longint unsigned lo, hi);
      lo = pos >> FRAC;
      hi = (pos + stp + (64'd1 << (FRAC-1))) >> FRAC;
      if (hi > lim) hi = lim;
      if (hi <= lo) hi = lo + 1;
   endfunction

   function automatic void clear_frame();
      col_cnt = 0; row_cnt = 0; hpos = 0; vpos = 0; hspan = 0; vspan = 0;
      row_acc = '{default: 0};
      for (int k = 0; k < 2*MAXD; k++) col_acc[k] = '{0, 0, 0};
   endfunction

   // one source pixel through both span passes
   function automatic void downscale_pixel(logic [23:0] d);
      longint unsigned w, h, dw, dh, hs, vs, c, r;
      longint unsigned x1, x2, y1, y2, n1, n2;
      int unsigned pix[3], avg[3], idx;
      thumb_px_type t;
      w = clampv(reg_sw, 1, MAXS);  h = clampv(reg_sh, 1, MAXS);
      dw = clampv(reg_dw, 1, MAXD); dh = clampv(reg_dh, 1, MAXD);
      hs = clampv(reg_hs, 4096, 25'h1FFFFFF);
      vs = clampv(reg_vs, 4096, 25'h1FFFFFF);
      c = col_cnt; r = row_cnt;
      for (int ch = 0; ch < 3; ch++) pix[ch] = 32'(d[8*ch +: 8]);

      if (hspan < dw) begin
         span_of(hpos, hs, w, x1, x2);
         if (x1 <= c && c < x2)
            for (int ch = 0; ch < 3; ch++) row_acc[0][ch] += pix[ch];
         if (hspan + 1 < dw) begin
            span_of(hpos + hs, hs, w, n1, n2);
            if (n1 <= c && c < n2)
               for (int ch = 0; ch < 3; ch++) row_acc[1][ch] += pix[ch];
         end
         if (c + 1 == x2) begin
            idx = hspan * 2;
            for (int ch = 0; ch < 3; ch++) avg[ch] = 32'(row_acc[0][ch] / (x2 - x1));
            if (vspan < dh) begin
               span_of(vpos, vs, h, y1, y2);
               if (y1 <= r && r < y2)
                  for (int ch = 0; ch < 3; ch++) col_acc[idx][ch] += avg[ch];
               if (vspan + 1 < dh) begin
                  span_of(vpos + vs, vs, h, n1, n2);
                  if (n1 <= r && r < n2)
                     for (int ch = 0; ch < 3; ch++) col_acc[idx+1][ch] += avg[ch];
               end
               if (r + 1 == y2) begin
                  t.x     = hspan[7:0];
                  t.y     = vspan[7:0];
                  t.red   = 8'(col_acc[idx][0] / (y2 - y1));
                  t.green = 8'(col_acc[idx][1] / (y2 - y1));
                  t.blue  = 8'(col_acc[idx][2] / (y2 - y1));
                  t.last  = 1'b1;
                  t.done  = (hspan + 1 == dw) && (vspan + 1 == dh);
                  thumb_q.push_back(t);
               end
            end
            row_acc[0] = row_acc[1];
            row_acc[1] = '{0, 0, 0};
            hspan++;
            hpos += hs;
         end
      end

      if (c + 1 >= w) begin
         if (vspan < dh) begin
            span_of(vpos, vs, h, y1, y2);
            if (r + 1 == y2) begin
               for (int k = 0; k < MAXD; k++) begin
                  col_acc[2*k]   = col_acc[2*k+1];
                  col_acc[2*k+1] = '{0, 0, 0};
               end
               vspan++;
               vpos += vs;
            end
         end
         col_cnt = 0; hspan = 0; hpos = 0;
         row_acc = '{default: 0};
         if (r + 1 >= h) clear_frame();
         else row_cnt = 32'(r + 1);
      end else begin
         col_cnt = 32'(c + 1);
      end
   endfunction

   always @(posedge clock) begin
      thumb_px_type got, want;
      if (reset) begin
         reg_sw = 1; reg_sh = 1; reg_dw = 1; reg_dh = 1;
         reg_hs = 4096; reg_vs = 4096;
         clear_frame();
         thumb_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bfd_pkg::CSR_SRC_WIDTH:  reg_sw = 32'(csr_data[bfd_pkg::SRC_CFG_W-1:0]);
               bfd_pkg::CSR_SRC_HEIGHT: reg_sh = 32'(csr_data[bfd_pkg::SRC_CFG_W-1:0]);
               bfd_pkg::CSR_DST_WIDTH:  reg_dw = 32'(csr_data[bfd_pkg::DST_CFG_W-1:0]);
               bfd_pkg::CSR_DST_HEIGHT: reg_dh = 32'(csr_data[bfd_pkg::DST_CFG_W-1:0]);
               bfd_pkg::CSR_HORIZ_STEP: reg_hs = 32'(csr_data[bfd_pkg::STEP_W-1:0]);
               bfd_pkg::CSR_VERT_STEP:  reg_vs = 32'(csr_data[bfd_pkg::STEP_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                   rsp_tdata[31:24], rsp_tdata[39:32], rsp_tlast, rsp_tuser};
            if (thumb_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected thumbnail beat %h", $realtime, got);
            end else begin
               want = thumb_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch x/y/r/g/b/last/done exp %h got %h",
                              $realtime, want, got);
               end
            end
         end
         // prediction after the compare so a same-edge result is never ours
         if (req_tvalid && req_tready) downscale_pixel(req_tdata);
      end
      pending = thumb_q.size();
   end

endmodule

// ===== sim/tb_box_filter_thumbnail_downscaler.sv =====
// ----------------------------------------------------------------------------
// tb_box_filter_thumbnail_downscaler : stimulus and verdict
// Drives source pixel frames over several register settings (directed corner
// frames, wide and tall frames, then random frames) with random idling on
// both sides; checking lives in bfd_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_box_filter_thumbnail_downscaler;

   // SETTLE covers the slowest pixel and the clearing pass that a frame end adds
   localparam int SETTLE   = 800;
   localparam int WATCHDOG = 6000;
   localparam int LONG_HOLD = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast, rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [bfd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bfd_pkg::CSR_DAT_W-1:0] csr_data  = '0;

   int errors, pending;
   int pixels_sent = 0;
   int idle_cnt = 0;
   bit quiet = 1'b0;        // no idling on either side in the closing stretch
   bit hold_req = 1'b0;     // toggled to ask the receiver for a long hold-off
   bit hold_seen = 1'b0;
   int hold_left = 0;
   int rx_gap = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   box_filter_thumbnail_downscaler DUT (.*);

   bfd_checker chk (.*);

   // receiver: random stall bursts, plus the long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else if (quiet || reset) begin
         rsp_tready <= 1'b1;
      end else if (rx_gap != 0) begin
         rx_gap     <= rx_gap - 1;
         rsp_tready <= (rx_gap == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         rx_gap     <= $urandom_range(1, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
         $display("** box_filter_thumbnail_downscaler: FAILED **");
         $finish;
      end
   end

   task automatic sender_gap();
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_pixel(logic [23:0] px);
      sender_gap();
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic write_reg(logic [bfd_pkg::CSR_IDX_W-1:0] idx,
                            logic [bfd_pkg::CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drain, let the block settle, then load all six registers
   task automatic configure(int unsigned sw, sh, dw, dh, hs, vs);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      write_reg(bfd_pkg::CSR_SRC_WIDTH,  bfd_pkg::CSR_DAT_W'(sw));
      write_reg(bfd_pkg::CSR_SRC_HEIGHT, bfd_pkg::CSR_DAT_W'(sh));
      write_reg(bfd_pkg::CSR_DST_WIDTH,  bfd_pkg::CSR_DAT_W'(dw));
      write_reg(bfd_pkg::CSR_DST_HEIGHT, bfd_pkg::CSR_DAT_W'(dh));
      write_reg(bfd_pkg::CSR_HORIZ_STEP, bfd_pkg::CSR_DAT_W'(hs));
      write_reg(bfd_pkg::CSR_VERT_STEP,  bfd_pkg::CSR_DAT_W'(vs));
   endtask

   // a frame is width*height pixels, sizes clamped the way the block does
   task automatic send_frame(int unsigned sw, sh);
      int unsigned w, h;
      w = (sw == 0) ? 1 :
          (sw > bfd_pkg::DEF_MAX_SRC_SIZE ? bfd_pkg::DEF_MAX_SRC_SIZE : sw);
      h = (sh == 0) ? 1 :
          (sh > bfd_pkg::DEF_MAX_SRC_SIZE ? bfd_pkg::DEF_MAX_SRC_SIZE : sh);
      for (int i = 0; i < w * h; i++) send_pixel(24'($urandom));
   endtask

   function automatic int unsigned pick_step(int unsigned s, d);
      int unsigned dd;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 4095);          // raised to minimum
         1: return $urandom & 25'h1FFFFFF;           // any 25-bit value
         default: begin
            dd = (d == 0) ? 1 : d;
            return (s * 4096 + dd / 2) / dd;
         end
      endcase
   endfunction

   initial begin
      int unsigned sw, sh, dw, dh;
      bit held = 1'b0;
      bit paused = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset setting is 1x1 to 1x1: every pixel comes straight back
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h0000FF);
      send_pixel(24'h00FF00);
      send_pixel(24'hFF0000);
      send_pixel(24'hA5A5A5);
      send_pixel(24'h5A5A5A);

      // zero sizes and steps are used as their minimum
      configure(0, 0, 0, 0, 0, 0);
      repeat (4) send_pixel(24'($urandom));

      // thumbnail larger than the source: spans past the source edge drop pixels
      configure(3, 2, 5, 3, 4096, 4096);
      send_frame(3, 2);

      // wide index and dst beyond its range
      configure(5, 3, 511, 300, 4096, 4096);
      send_frame(5, 3);

      // a wide single-row frame and a tall single-column frame
      configure(128, 1, 64, 1, 8192, 4096);
      send_frame(128, 1);
      configure(1, 128, 1, 64, 4096, 8192);
      send_frame(1, 128);

      // a step with only its top bit set into a tiny thumbnail
      configure(7, 5, 1, 1, 25'h1000000, 25'h1000000);
      send_frame(7, 5);

      while (pixels_sent < 600) begin
         sw = $urandom_range(1, 12);
         sh = $urandom_range(1, 10);
         dw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, sw);
         dh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, sh);
         configure(sw, sh, dw, dh, pick_step(sw, dw), pick_step(sh, dh));
         if (pixels_sent > 540) quiet = 1'b1;
         if (!held && pixels_sent > 350) begin
            hold_req = ~hold_req;   // receiver stalls while we keep offering
            held = 1'b1;
         end
         for (int i = 0; i < sw * sh; i++) begin
            if (!paused && pixels_sent > 450 && i == sw * sh / 2) begin
               // sender waits for the output side to catch up mid-frame
               req_tvalid <= 1'b0;
               @(posedge clock);
               wait (pending == 0);
               @(posedge clock);
               paused = 1'b1;
            end
            send_pixel(24'($urandom));
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);

      if (errors == 0 && pending == 0)
         $display("** box_filter_thumbnail_downscaler: PASSED **");
      else
         $display("** box_filter_thumbnail_downscaler: FAILED **");
      $finish;
   end

endmodule

// ===== box_filter_thumbnail_downscaler.f =====
rtl/bfd_pkg.sv
rtl/bfd_span_bounds.sv
rtl/bfd_divider.sv
rtl/box_filter_thumbnail_downscaler.sv
sim/bfd_checker.sv
sim/tb_box_filter_thumbnail_downscaler.sv
